// ----- sv/mcl_pkg.sv -----
package mcl_pkg;

   // Field widths of one item and of one result
   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 64;
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 3;
   localparam int COUNT_W  = 3;

   // Default list depth
   localparam int DEPTH_DEFAULT = 5;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_SAVE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // Control for each cell of the row; save_go and any_hit are shared by every cell
   typedef struct packed {
      logic save_go;    // save with a nonzero key this cycle
      logic any_hit;    // key found somewhere in the occupied entries
      logic fill_edge;  // cell index is at or below the entry count
   } cell_ctl_type;

endpackage

// ----- sv/mru_credential_list.sv -----
// Channel  | Direction | Handshake       | Payload
// ---------+-----------+-----------------+---------------------------------------------------
// req      | in        | start && !busy  | action, entry_key, entry_value, read_index
// rsp      | out       | rsp_valid pulse | entry_count, read_key, read_value, read_valid,
//          |           |                 | key_was_present, save_ignored
//
// One item per cycle while busy is low: every cell compares its key and shifts in the same cycle, and the
// result shows on rsp_ for one cycle after the accepting edge. The compare-and-shift row
// of DEPTH cells, with its first-hit chain, sets that figure.
// Synchronous reset empties the list and sets busy high; busy clears once reset is released.
// The receiver cannot stall: rsp_valid lasts exactly one cycle and is never held.
module mru_credential_list import mcl_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [KEY_W-1:0]    req_entry_key,
   input  logic [VALUE_W-1:0]  req_entry_value,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_valid,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   output logic [KEY_W-1:0]    rsp_read_key,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_read_valid,
   output logic                rsp_key_was_present,
   output logic                rsp_save_ignored
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff;
   logic               accept;
   cell_ctl_type       ctl [DEPTH];
   logic [DEPTH-1:0]   occupied;
   logic [DEPTH-1:0]   hit;
   logic [DEPTH-1:0]   hit_chain;
   logic [DEPTH-1:0]   rd_sel;
   logic [KEY_W-1:0]   cell_key   [DEPTH];
   logic [VALUE_W-1:0] cell_value [DEPTH];
   logic               save_go;
   logic               any_hit;
   logic [EW-1:0]      cnt_ext;

   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_entry_count_ff, rsp_entry_count_in;
   logic [KEY_W-1:0]   rsp_read_key_ff, rsp_read_key_in;
   logic [VALUE_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic               rsp_read_valid_ff, rsp_read_valid_in;
   logic               rsp_key_was_present_ff, rsp_key_was_present_in;
   logic               rsp_save_ignored_ff, rsp_save_ignored_in;

   assign accept  = start && !busy_ff;
   assign save_go = accept && (req_action == ACT_SAVE) && (req_entry_key != '0);
   assign any_hit = |hit;

   // Build the row of cells; cell zero takes the new entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i]      = CW'(i) < cnt_ff;
      assign ctl[i].save_go   = save_go;
      assign ctl[i].any_hit   = any_hit;
      assign ctl[i].fill_edge = CW'(i) <= cnt_ff;
      assign rd_sel[i]        = occupied[i] && (32'(req_read_index) == i);

      if (i == 0) begin : g_head
         mcl_cell u_cell (
            .clock     (clock),
            .ctl       (ctl[i]),
            .occupied  (occupied[i]),
            .hit_above (1'b0),
            .cmp_key   (req_entry_key),
            .up_key    (req_entry_key),
            .up_value  (req_entry_value),
            .key       (cell_key[i]),
            .value     (cell_value[i]),
            .hit       (hit[i]),
            .hit_chain (hit_chain[i])
         );
      end else begin : g_body
         mcl_cell u_cell (
            .clock     (clock),
            .ctl       (ctl[i]),
            .occupied  (occupied[i]),
            .hit_above (hit_chain[i-1]),
            .cmp_key   (req_entry_key),
            .up_key    (cell_key[i-1]),
            .up_value  (cell_value[i-1]),
            .key       (cell_key[i]),
            .value     (cell_value[i]),
            .hit       (hit[i]),
            .hit_chain (hit_chain[i])
         );
      end
   end

   // Work out the next count and the result fields
   always_comb begin
      cnt_in                 = cnt_ff;
      rsp_read_key_in        = '0;
      rsp_read_value_in      = '0;
      rsp_read_valid_in      = 1'b0;
      rsp_key_was_present_in = 1'b0;
      rsp_save_ignored_in    = 1'b0;
      unique case (req_action)
         ACT_SAVE: begin
            if (req_entry_key == '0) begin
               rsp_save_ignored_in = 1'b1;
            end else if (any_hit) begin
               rsp_key_was_present_in = 1'b1;
            end else if (cnt_ff < CW'(DEPTH)) begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ACT_CLEAR: begin
            cnt_in = '0;
         end
         ACT_READ: begin
            rsp_read_valid_in = |rd_sel;
            for (int i = 0; i < DEPTH; i++) begin
               if (rd_sel[i]) begin
                  rsp_read_key_in   = cell_key[i];
                  rsp_read_value_in = cell_value[i];
               end
            end
         end
         default: begin
         end
      endcase
      cnt_ext            = EW'(cnt_in);
      rsp_entry_count_in = cnt_ext[COUNT_W-1:0];
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // Register the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_entry_count_ff     <= rsp_entry_count_in;
         rsp_read_key_ff        <= rsp_read_key_in;
         rsp_read_value_ff      <= rsp_read_value_in;
         rsp_read_valid_ff      <= rsp_read_valid_in;
         rsp_key_was_present_ff <= rsp_key_was_present_in;
         rsp_save_ignored_ff    <= rsp_save_ignored_in;
      end
   end

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_entry_count     = rsp_entry_count_ff;
   assign rsp_read_key        = rsp_read_key_ff;
   assign rsp_read_value      = rsp_read_value_ff;
   assign rsp_read_valid      = rsp_read_valid_ff;
   assign rsp_key_was_present = rsp_key_was_present_ff;
   assign rsp_save_ignored    = rsp_save_ignored_ff;

   // Count never passes the list depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // Each accepted item gives one result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept))
      else $error("result strobe does not follow accept");

   // A valid read never returns the empty key
   a_read_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_valid) |-> (rsp_read_key != '0))
      else $error("valid read returned a zero key");

   // A save is either ignored or a hit, never both
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_key_was_present, rsp_save_ignored}))
      else $error("conflicting save flags");

endmodule

// ----- sv/mcl_cell.sv -----
module mcl_cell import mcl_pkg::*; (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               occupied,
   input  logic               hit_above,
   input  logic [KEY_W-1:0]   cmp_key,
   input  logic [KEY_W-1:0]   up_key,
   input  logic [VALUE_W-1:0] up_value,
   output logic [KEY_W-1:0]   key,
   output logic [VALUE_W-1:0] value,
   output logic               hit,
   output logic               hit_chain
);

   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               shift;

   // Match only entries that hold live data
   assign hit       = occupied && (key_ff == cmp_key);
   assign hit_chain = hit_above || hit;

   // Take the neighbor's entry when this cell lies at or above the moved slot
   assign shift = ctl.save_go && !hit_above && (ctl.any_hit || ctl.fill_edge);

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= up_key;
         value_ff <= up_value;
      end
   end

   assign key   = key_ff;
   assign value = value_ff;

endmodule

// ----- dv/tb_mru_credential_list.sv -----
`timescale 1ns / 100ps

module tb_mru_credential_list;
   import mcl_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int QUIET_FIRST = 200;
   localparam int QUIET_LAST  = 300;

   // One command to the list, with a flag that holds it until the list has answered everything
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]  index;
      logic                drain;
   } list_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               valid;
      logic               present;
      logic               ignored;
   } list_rsp_type;

   logic                clock;
   logic                reset;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = '0;
   logic [KEY_W-1:0]    req_entry_key = '0;
   logic [VALUE_W-1:0]  req_entry_value = '0;
   logic [INDEX_W-1:0]  req_read_index = '0;
   logic                rsp_valid;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic [KEY_W-1:0]    rsp_read_key;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic                rsp_read_valid;
   logic                rsp_key_was_present;
   logic                rsp_save_ignored;

   list_cmd_type pending_cmds[$];
   list_rsp_type expected_rsps[$];
   int           accepted_count = 0;
   int           error_count = 0;
   int           total_cmds = 0;

   // Mirror of the list contents
   logic [KEY_W-1:0]   key_mirror[LIST_DEPTH];
   logic [VALUE_W-1:0] value_mirror[LIST_DEPTH];
   int                 count_mirror = 0;

   mru_credential_list #(.DEPTH(LIST_DEPTH)) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_entry_key       (req_entry_key),
      .req_entry_value     (req_entry_value),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_read_key        (rsp_read_key),
      .rsp_read_value      (rsp_read_value),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_key_was_present (rsp_key_was_present),
      .rsp_save_ignored    (rsp_save_ignored)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one command to the mirror and return what the list must answer
   function automatic list_rsp_type apply_to_list(input list_cmd_type cmd);
      list_rsp_type rsp;
      int           hit;
      int           top;
      rsp = '0;
      hit = -1;
      case (cmd.action)
         ACT_SAVE: begin
            if (cmd.key == '0) begin
               rsp.ignored = 1'b1;
            end else begin
               // find the first live match from the front
               for (int i = 0; i < count_mirror; i++) begin
                  if (hit < 0 && key_mirror[i] == cmd.key) hit = i;
               end
               if (hit >= 0) begin
                  top = hit;
                  rsp.present = 1'b1;
               end else begin
                  top = (count_mirror < LIST_DEPTH) ? count_mirror : LIST_DEPTH - 1;
               end
               // shift down and insert at the front
               for (int i = top; i > 0; i--) begin
                  key_mirror[i]   = key_mirror[i-1];
                  value_mirror[i] = value_mirror[i-1];
               end
               key_mirror[0]   = cmd.key;
               value_mirror[0] = cmd.value;
               if (hit < 0 && count_mirror < LIST_DEPTH) count_mirror++;
            end
         end
         ACT_CLEAR: count_mirror = 0;
         ACT_READ: begin
            if (int'(cmd.index) < count_mirror) begin
               rsp.key   = key_mirror[cmd.index];
               rsp.value = value_mirror[cmd.index];
               rsp.valid = 1'b1;
            end
         end
         default: ;
      endcase
      rsp.count = count_mirror[COUNT_W-1:0];
      return rsp;
   endfunction

   function automatic string fmt_rsp(input list_rsp_type rsp);
      return $sformatf("count=%0d key=%h value=%h valid=%b present=%b ignored=%b",
                       rsp.count, rsp.key, rsp.value, rsp.valid, rsp.present, rsp.ignored);
   endfunction

   task automatic add_cmd(input logic [ACTION_W-1:0] action, input logic [KEY_W-1:0] key,
                          input logic [VALUE_W-1:0] value, input logic [INDEX_W-1:0] index,
                          input logic drain);
      list_cmd_type cmd;
      cmd.action = action;
      cmd.key    = key;
      cmd.value  = value;
      cmd.index  = index;
      cmd.drain  = drain;
      pending_cmds.push_back(cmd);
   endtask

   // Driver: predict on each accepted item, then present the next one or idle
   always @(posedge clock) begin
      list_cmd_type sent;
      list_cmd_type nxt;
      logic         fire;
      logic         hold_off;
      if (reset) begin
         start <= 1'b0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            sent.action = req_action;
            sent.key    = req_entry_key;
            sent.value  = req_entry_value;
            sent.index  = req_read_index;
            sent.drain  = 1'b0;
            expected_rsps.push_back(apply_to_list(sent));
            accepted_count++;
         end
         if (!start || fire) begin
            hold_off = (pending_cmds.size() == 0);
            // hold until every outstanding result is back
            if (!hold_off && pending_cmds[0].drain && expected_rsps.size() != 0)
               hold_off = 1'b1;
            // random gaps, except in one quiet stretch
            if (!hold_off && !(accepted_count >= QUIET_FIRST && accepted_count < QUIET_LAST)
                && $urandom_range(99) < 12)
               hold_off = 1'b1;
            if (hold_off) begin
               start <= 1'b0;
            end else begin
               nxt = pending_cmds.pop_front();
               start           <= 1'b1;
               req_action      <= nxt.action;
               req_entry_key   <= nxt.key;
               req_entry_value <= nxt.value;
               req_read_index  <= nxt.index;
            end
         end
      end
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      list_rsp_type seen;
      list_rsp_type want;
      if (!reset && rsp_valid) begin
         seen.count   = rsp_entry_count;
         seen.key     = rsp_read_key;
         seen.value   = rsp_read_value;
         seen.valid   = rsp_read_valid;
         seen.present = rsp_key_was_present;
         seen.ignored = rsp_save_ignored;
         if (expected_rsps.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result: %s", fmt_rsp(seen));
         end else begin
            want = expected_rsps.pop_front();
            if (seen !== want) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected %s\n          actual   %s",
                           fmt_rsp(want), fmt_rsp(seen));
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [KEY_W-1:0]    key_pool[8];
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      int                  pick;

      // empty list, unused code, zero key
      add_cmd(ACT_READ, $urandom, {$urandom, $urandom}, 3'd0, 1'b0);
      add_cmd(ACT_UNUSED, $urandom, {$urandom, $urandom}, 3'd7, 1'b0);
      add_cmd(ACT_SAVE, '0, '1, 3'd5, 1'b0);
      // fill past the depth so the oldest drops
      add_cmd(ACT_SAVE, 32'd1, '0, 3'd0, 1'b0);
      add_cmd(ACT_SAVE, '1, '1, 3'd7, 1'b0);
      add_cmd(ACT_SAVE, 32'd3, 64'h0123_4567_89ab_cdef, 3'd0, 1'b0);
      add_cmd(ACT_SAVE, 32'd4, 64'hfedc_ba98_7654_3210, 3'd0, 1'b0);
      add_cmd(ACT_SAVE, 32'd5, 64'h5555_aaaa_5555_aaaa, 3'd0, 1'b0);
      add_cmd(ACT_SAVE, 32'd6, 64'haaaa_5555_aaaa_5555, 3'd0, 1'b0);
      // reads inside and beyond the count
      add_cmd(ACT_READ, '0, '0, 3'd0, 1'b0);
      add_cmd(ACT_READ, '0, '0, 3'd4, 1'b0);
      add_cmd(ACT_READ, '1, '1, 3'd5, 1'b0);
      add_cmd(ACT_READ, '1, '1, 3'd7, 1'b0);
      // hits in the middle, at the front and at the tail, then a miss on a full list
      add_cmd(ACT_SAVE, 32'd4, 64'h1111_2222_3333_4444, 3'd0, 1'b0);
      add_cmd(ACT_SAVE, 32'd4, 64'h9999_8888_7777_6666, 3'd0, 1'b0);
      add_cmd(ACT_SAVE, '1, 64'hdead_beef_cafe_f00d, 3'd0, 1'b0);
      add_cmd(ACT_SAVE, 32'd1, 64'h1, 3'd0, 1'b0);
      add_cmd(ACT_READ, '0, '0, 3'd4, 1'b0);
      // clear leaves stale entries that must stay hidden
      add_cmd(ACT_CLEAR, $urandom, {$urandom, $urandom}, 3'd2, 1'b0);
      add_cmd(ACT_READ, '0, '0, 3'd0, 1'b0);
      add_cmd(ACT_SAVE, 32'd6, 64'h7, 3'd0, 1'b1);
      add_cmd(ACT_READ, '0, '0, 3'd0, 1'b0);
      add_cmd(ACT_READ, '0, '0, 3'd1, 1'b0);
      add_cmd(ACT_SAVE, '0, 64'h8, 3'd1, 1'b0);

      // random part: a small key pool keeps hits and evictions frequent
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int n = 0; n < 420; n++) begin
         if (n % 60 == 59) key_pool[$urandom_range(7)] = $urandom;
         pick = $urandom_range(99);
         key  = key_pool[$urandom_range(7)];
         if (pick < 50) begin
            action = ACT_SAVE;
            if (pick < 3) key = '0;
            else if (pick < 10) key = $urandom;
         end else if (pick < 88) begin
            action = ACT_READ;
         end else if (pick < 94) begin
            action = ACT_CLEAR;
         end else begin
            action = ACT_UNUSED;
         end
         add_cmd(action, key, {$urandom, $urandom}, 3'($urandom_range(7)),
                 (n == 150 || n == 330));
      end
      total_cmds = pending_cmds.size();

      // wait for every item, every result, then a short tail
      while (accepted_count < total_cmds) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
